/* hdl/modexp_pkg.sv */
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared constants and types of the modular exponentiation core.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH + 1);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_SQUARE,
    ST_MULT,
    ST_FINISH
  } modexp_state_t;

endpackage

/* hdl/modular_exponentiation_core.sv */
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Computes base ^ exponent mod modulus by left-to-right square and multiply.
// ----------------------------------------------------------------------------
// One item is worked at a time and the input is not ready until its result
// has been handed to the output register. Every modular product goes through
// one shared bit-serial multiplier, one multiplier bit per cycle, which then
// hands over the product. An item costs one such product to reduce the base,
// a scan of the exponent bits from the top down to the leading one, then one
// squaring for every lower bit and one more product for every lower one bit.
// When the exponent is zero or the modulus is below two the result is settled
// at once. A result still waiting in the output register holds the next one
// back until it is taken. The modulus register is written through the cfg
// port, which is always ready, and resets to 2.
module modular_exponentiation_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,        // modulus
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,    // [31:0] base_value, [63:32] exponent
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata     // [31:0] power_result
);
  import modexp_pkg::*;

  modexp_state_t state;
  modexp_state_t state_next;
  word_t         modulus;
  word_t         base_red;
  word_t         base_red_next;
  word_t         acc;
  word_t         acc_next;
  word_t         e;
  word_t         e_next;
  cnt_t          cnt;
  cnt_t          cnt_next;
  logic          out_load;

  logic          mm_start;
  word_t         mm_a;
  word_t         mm_b;
  logic          mm_done;
  word_t         mm_result;

  word_t         in_base;
  word_t         in_exp;

  assign in_base = s_axis_tdata[WIDTH-1:0];
  assign in_exp  = s_axis_tdata[32+WIDTH-1:32];

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);

  modexp_mulmod u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (mm_start),
    .op_a    (mm_a),
    .op_b    (mm_b),
    .modulus (modulus),
    .done    (mm_done),
    .result  (mm_result)
  );

  always_comb begin
    state_next    = state;
    base_red_next = base_red;
    acc_next      = acc;
    e_next        = e;
    cnt_next      = cnt;
    mm_start      = 1'b0;
    mm_a          = acc;
    mm_b          = acc;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          e_next   = in_exp;
          cnt_next = CNT_W'(WIDTH);
          if (modulus <= WIDTH'(1)) begin
            acc_next   = '0;
            state_next = ST_FINISH;
          end else if (in_exp == '0) begin
            acc_next   = WIDTH'(1);
            state_next = ST_FINISH;
          end else begin
            mm_start   = 1'b1;
            mm_a       = WIDTH'(1);
            mm_b       = in_base;
            state_next = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mm_done) begin
          base_red_next = mm_result;
          acc_next      = mm_result;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        e_next   = {e[WIDTH-2:0], 1'b0};
        cnt_next = cnt - 1'b1;
        if (e[WIDTH-1]) begin
          if (cnt == CNT_W'(1)) begin
            state_next = ST_FINISH;
          end else begin
            mm_start   = 1'b1;
            state_next = ST_SQUARE;
          end
        end
      end
      ST_SQUARE: begin
        if (mm_done) begin
          acc_next = mm_result;
          if (e[WIDTH-1]) begin
            mm_start   = 1'b1;
            mm_a       = base_red;
            mm_b       = mm_result;
            state_next = ST_MULT;
          end else begin
            e_next   = {e[WIDTH-2:0], 1'b0};
            cnt_next = cnt - 1'b1;
            if (cnt == CNT_W'(1)) begin
              state_next = ST_FINISH;
            end else begin
              mm_start   = 1'b1;
              mm_a       = mm_result;
              mm_b       = mm_result;
              state_next = ST_SQUARE;
            end
          end
        end
      end
      ST_MULT: begin
        if (mm_done) begin
          acc_next = mm_result;
          e_next   = {e[WIDTH-2:0], 1'b0};
          cnt_next = cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state_next = ST_FINISH;
          end else begin
            mm_start   = 1'b1;
            mm_a       = mm_result;
            mm_b       = mm_result;
            state_next = ST_SQUARE;
          end
        end
      end
      ST_FINISH: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      modulus       <= WIDTH'(2);
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        modulus <= cfg_data[WIDTH-1:0];
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    base_red <= base_red_next;
    acc      <= acc_next;
    e        <= e_next;
    cnt      <= cnt_next;
    if (out_load) begin
      m_axis_tdata <= acc;
    end
  end

endmodule

/* hdl/modexp_mulmod.sv */
// ----------------------------------------------------------------------------
// modexp_mulmod
// Bit-serial modular multiplier: one multiplier bit per cycle, doubling and
// conditional add, each reduced by one compare and subtract.
// ----------------------------------------------------------------------------
module modexp_mulmod (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  modexp_pkg::word_t    op_a,
  input  modexp_pkg::word_t    op_b,
  input  modexp_pkg::word_t    modulus,
  output logic                 done,
  output modexp_pkg::word_t    result
);
  import modexp_pkg::*;

  word_t a;
  word_t b;
  word_t r;
  word_t m;
  cnt_t  cnt;
  logic  busy;

  logic [WIDTH:0] dbl_sum;
  word_t          dbl;
  logic [WIDTH:0] add_sum;
  word_t          r_next;

  always_comb begin
    dbl_sum = {1'b0, r} + {1'b0, r};
    if (dbl_sum >= {1'b0, m}) begin
      dbl = WIDTH'(dbl_sum - {1'b0, m});
    end else begin
      dbl = dbl_sum[WIDTH-1:0];
    end
    add_sum = {1'b0, dbl} + {1'b0, a};
    if (!b[WIDTH-1]) begin
      r_next = dbl;
    end else if (add_sum >= {1'b0, m}) begin
      r_next = WIDTH'(add_sum - {1'b0, m});
    end else begin
      r_next = add_sum[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a <= op_a;
      b <= op_b;
      m <= modulus;
      r <= '0;
    end else if (busy) begin
      r <= r_next;
      b <= {b[WIDTH-2:0], 1'b0};
    end
  end

  assign result = r;

endmodule

/* hdl/modexp_checker.sv */
// ----------------------------------------------------------------------------
// modexp_checker
// Port-level assertions for the modular exponentiation core, bound to it.
// ----------------------------------------------------------------------------
module modexp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // An accepted item occupies the core and takes its input out of ready.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted item");

  // A new result appears only as the core returns to idle.
  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result shown while the core is still busy");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output item changed while stalled");

endmodule

bind modular_exponentiation_core modexp_checker u_modexp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* sim/tb_modular_exponentiation_core.sv */
// ----------------------------------------------------------------------------
// tb_modular_exponentiation_core
// Self-checking bench for the modular exponentiation core. A directed table
// covers the reset modulus, moduli of zero, one and all ones, primes and the
// extremes of base and exponent. Random phases follow, each under its own
// modulus, with random gaps on both streams save in one. Results are checked
// in order against table values or the bench's square-and-multiply predictor.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation_core;
  timeunit 1ns;
  timeprecision 1ps;

  import modexp_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int PHASE_ITEMS = 40;
  localparam int NUM_PHASES  = 7;
  localparam int LONG_HOLD   = 6000;
  localparam int NUM_ROWS    = 25;

  typedef enum logic {ROW_MODULUS, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    word_t     base_or_mod;
    word_t     exponent;
    logic      typed;
    word_t     want;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  word_t expected_powers[$];
  word_t modulus_now;
  int    error_count = 0;
  int    cycle_count = 0;
  bit    hold_request = 1'b0;
  bit    no_idle = 1'b0;

  directed_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_ITEM,    32'd3,          32'd5,          1'b1, 32'd1},
    '{ROW_ITEM,    32'd0,          32'd0,          1'b1, 32'd1},
    '{ROW_ITEM,    32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'd1},
    '{ROW_ITEM,    32'd2,          32'd7,          1'b1, 32'd0},
    '{ROW_MODULUS, 32'd0,          32'd0,          1'b0, 32'd0},
    '{ROW_ITEM,    32'd123,        32'd45,         1'b1, 32'd0},
    '{ROW_ITEM,    32'd0,          32'd0,          1'b1, 32'd0},
    '{ROW_MODULUS, 32'd1,          32'd0,          1'b0, 32'd0},
    '{ROW_ITEM,    32'd7,          32'd0,          1'b1, 32'd0},
    '{ROW_ITEM,    32'hFFFF_FFFF,  32'd3,          1'b1, 32'd0},
    '{ROW_MODULUS, 32'hFFFF_FFFF,  32'd0,          1'b0, 32'd0},
    '{ROW_ITEM,    32'hFFFF_FFFF,  32'd5,          1'b1, 32'd0},
    '{ROW_ITEM,    32'hFFFF_FFFE,  32'hFFFF_FFFF,  1'b0, 32'd0},
    '{ROW_ITEM,    32'd0,          32'd0,          1'b1, 32'd1},
    '{ROW_ITEM,    32'd0,          32'd5,          1'b1, 32'd0},
    '{ROW_ITEM,    32'd1,          32'hFFFF_FFFF,  1'b1, 32'd1},
    '{ROW_MODULUS, 32'd13,         32'd0,          1'b0, 32'd0},
    '{ROW_ITEM,    32'd2,          32'd12,         1'b1, 32'd1},
    '{ROW_ITEM,    32'd100,        32'd1,          1'b1, 32'd9},
    '{ROW_ITEM,    32'd5,          32'h8000_0000,  1'b0, 32'd0},
    '{ROW_ITEM,    32'd13,         32'd3,          1'b1, 32'd0},
    '{ROW_MODULUS, 32'hFFFF_FFFB,  32'd0,          1'b0, 32'd0},
    '{ROW_ITEM,    32'hFFFF_FFFA,  32'd2,          1'b1, 32'd1},
    '{ROW_ITEM,    32'd3,          32'hFFFF_FFFA,  1'b1, 32'd1},
    '{ROW_ITEM,    32'h1234_5678,  32'h9ABC_DEF0,  1'b0, 32'd0}
  };

  modular_exponentiation_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic word_t predict_power(word_t modulus, word_t base_in, word_t exp_in);
    logic [63:0] m;
    logic [63:0] b;
    logic [63:0] acc;
    int          top;
    int          i;
    if (modulus == '0) begin
      return '0;
    end
    m = 64'(modulus);
    b = 64'(base_in) % m;
    if (exp_in == '0) begin
      return (m == 64'd1) ? word_t'(0) : word_t'(1);
    end
    top = WIDTH - 1;
    while (top > 0 && !exp_in[top]) begin
      top--;
    end
    acc = b;
    for (i = top - 1; i >= 0; i--) begin
      acc = (acc * acc) % m;
      if (exp_in[i]) begin
        acc = (acc * b) % m;
      end
    end
    return acc[WIDTH-1:0];
  endfunction

  task automatic send_power_item(input word_t base_in, input word_t exp_in,
                                 input logic typed, input word_t want);
    int gap;
    gap = 0;
    if (!no_idle) begin
      if ($urandom_range(0, 31) == 0) begin
        gap = $urandom_range(20, 80);
      end else if ($urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {exp_in, base_in};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    expected_powers.push_back(typed ? want : predict_power(modulus_now, base_in, exp_in));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_powers.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_modulus(input word_t value);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    modulus_now = value;
  endtask

  task automatic send_random_item();
    word_t base_in;
    word_t exp_in;
    int    len;
    case ($urandom_range(0, 9))
      0:       base_in = '0;
      1:       base_in = '1;
      2:       base_in = word_t'($urandom_range(0, 15));
      3:       base_in = modulus_now + word_t'($urandom_range(0, 15));
      default: base_in = word_t'($urandom);
    endcase
    if ($urandom_range(0, 15) == 0) begin
      exp_in = '1;
    end else begin
      len = $urandom_range(0, WIDTH);
      if (len == 0) begin
        exp_in = '0;
      end else begin
        exp_in = word_t'($urandom) & (word_t'('1) >> (WIDTH - len));
        exp_in[len-1] = 1'b1;
      end
    end
    send_power_item(base_in, exp_in, 1'b0, '0);
  endtask

  initial begin
    int hold_left;
    int rx_gap;
    m_axis_tready = 1'b0;
    hold_left     = 0;
    rx_gap        = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!no_idle) begin
          if ($urandom_range(0, 39) == 0) begin
            rx_gap = $urandom_range(20, 150);
          end else if ($urandom_range(0, 3) == 0) begin
            rx_gap = $urandom_range(1, 3);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_powers.size() == 0) begin
        $error("power_result: no result expected, got %h", m_axis_tdata);
        error_count++;
      end else begin
        if (m_axis_tdata !== expected_powers[0]) begin
          $error("power_result: expected %h, got %h", expected_powers[0], m_axis_tdata);
          error_count++;
        end
        void'(expected_powers.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int    r;
    int    p;
    int    k;
    word_t phase_mod;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    modulus_now   = word_t'(2);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_MODULUS) begin
        write_modulus(directed_rows[r].base_or_mod);
      end else begin
        send_power_item(directed_rows[r].base_or_mod, directed_rows[r].exponent,
                        directed_rows[r].typed, directed_rows[r].want);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       phase_mod = '1;
        1:       phase_mod = word_t'($urandom_range(2, 255));
        2:       phase_mod = 32'hFFFF_FFFB;
        3:       phase_mod = word_t'($urandom) | word_t'(1);
        4:       phase_mod = word_t'(65537);
        5:       phase_mod = word_t'(2);
        default: phase_mod = word_t'($urandom) | 32'h8000_0000;
      endcase
      write_modulus(phase_mod);
      no_idle = (p == 4);
      if (p == 0) begin
        hold_request = 1'b1;
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 3 && k == PHASE_ITEMS / 2) begin
          drain_results();
        end
        send_random_item();
      end
    end
    no_idle = 1'b0;

    drain_results();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
